>>> rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code bit packer: operation codes,
// field widths and the command that passes from the table front to the packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam int SYMBOL_COUNT = 128;
  localparam int SYM_W        = 7;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_W        = 6;
  localparam int BITS_W       = 32;
  localparam int BYTE_BITS    = 8;
  localparam int PEND_W       = BYTE_BITS - 1;
  localparam int ACC_W        = BITS_W + PEND_W;
  localparam int CNT_W        = 6;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  // one command for the packer
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [BITS_W-1:0] bits;
  } cmd_t;

endpackage

>>> rtl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, keeps the code table and turns encode and flush items into
// masked commands for the packer queue. Loads end here.
// ----------------------------------------------------------------------------
module hcbp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
  input  logic [hcbp_pkg::BITS_W-1:0]  code_bits,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output hcbp_pkg::cmd_t               cmd
);

  logic [hcbp_pkg::LEN_W-1:0]  len_mem  [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::BITS_W-1:0] bits_mem [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::SYMBOL_COUNT-1:0] len_vld;

  logic [hcbp_pkg::LEN_W-1:0]  rd_len;
  logic [hcbp_pkg::BITS_W-1:0] rd_bits;
  logic                        rd_vld;
  logic                        s1_valid;
  logic                        s1_valid_next;
  logic                        s1_flush;

  hcbp_pkg::op_t               op;
  logic                        in_fire;
  logic                        is_load;
  logic [hcbp_pkg::LEN_W-1:0]  sat_len;
  logic [hcbp_pkg::LEN_W-1:0]  eff_len;

  assign op       = hcbp_pkg::op_t'(operation);
  assign in_ready = !s1_valid || cmd_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_load  = (op == hcbp_pkg::OP_LOAD);

  // lengths above the maximum saturate on load
  assign sat_len = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
                   hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : code_length;

  // code table write and registered read
  always_ff @(posedge clk) begin
    if (in_fire && is_load) begin
      len_mem[symbol]  <= sat_len;
      bits_mem[symbol] <= code_bits;
    end
    if (in_fire) begin
      rd_len  <= len_mem[symbol];
      rd_bits <= bits_mem[symbol];
      rd_vld  <= len_vld[symbol];
      s1_flush <= (op == hcbp_pkg::OP_FLUSH);
    end
  end

  // per-entry valid bits, an unwritten entry has length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (in_fire && is_load) begin
      len_vld[symbol] <= 1'b1;
    end
  end

  // lookup stage occupancy
  always_comb begin
    s1_valid_next = s1_valid;
    if (in_fire) begin
      s1_valid_next = (op == hcbp_pkg::OP_ENCODE) || (op == hcbp_pkg::OP_FLUSH);
    end else if (cmd_ready) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // command toward the packer, code bits masked to the length
  assign eff_len       = rd_vld ? rd_len : '0;
  assign cmd_valid     = s1_valid;
  assign cmd.is_flush  = s1_flush;
  assign cmd.len       = s1_flush ? '0 : eff_len;
  assign cmd.bits      = s1_flush ? '0 :
                         (rd_bits & ~({hcbp_pkg::BITS_W{1'b1}} << eff_len));

endmodule

>>> rtl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short command queue between the table front and the packer.
// ----------------------------------------------------------------------------
module hcbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hcbp_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hcbp_pkg::cmd_t pop_cmd
);

  hcbp_pkg::cmd_t                entries [hcbp_pkg::QUEUE_DEPTH];
  logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hcbp_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [hcbp_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    QCNT_INC = {{(hcbp_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign push_ready = (count != hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_INC(do_push) - QCNT_INC(do_pop);
    end
  end

endmodule

>>> rtl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: appends commands to the pending bits, sends one byte a cycle when
// out_ready allows, via the output register; pads the partial byte on flush.
// ----------------------------------------------------------------------------
module hcbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  hcbp_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     packed_byte,
  output logic           last_of_run
);

  logic [hcbp_pkg::ACC_W-1:0] acc;
  logic [hcbp_pkg::ACC_W-1:0] acc_next;
  logic [hcbp_pkg::CNT_W-1:0] cnt;
  logic [hcbp_pkg::CNT_W-1:0] cnt_next;
  logic                       flush_act;
  logic                       flush_act_next;

  logic                       out_ok;
  logic                       emit;
  logic                       emit_last;
  logic [hcbp_pkg::ACC_W-1:0] base_acc;
  logic [hcbp_pkg::CNT_W-1:0] base_cnt;
  logic                       base_fl;
  logic [hcbp_pkg::ACC_W-1:0] shifted;

  assign out_ok = !out_valid || out_ready;
  assign emit   = out_ok && (flush_act || (cnt >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS)));
  assign emit_last = flush_act || (cnt < hcbp_pkg::CNT_W'(2 * hcbp_pkg::BYTE_BITS));

  // state after this cycle's byte, then append a popped command
  always_comb begin
    base_acc = acc;
    base_cnt = cnt;
    base_fl  = flush_act;
    if (emit) begin
      if (flush_act) begin
        base_acc = '0;
        base_cnt = '0;
        base_fl  = 1'b0;
      end else begin
        base_acc = acc >> hcbp_pkg::BYTE_BITS;
        base_cnt = cnt - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS);
      end
    end

    cmd_ready = !base_fl && (base_cnt < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_BITS));
    shifted   = {{hcbp_pkg::PEND_W{1'b0}}, cmd.bits} << base_cnt[2:0];

    acc_next       = base_acc;
    cnt_next       = base_cnt;
    flush_act_next = base_fl;
    if (cmd_valid && cmd_ready) begin
      if (cmd.is_flush) begin
        flush_act_next = (base_cnt != '0);
      end else begin
        acc_next = {{hcbp_pkg::BITS_W{1'b0}}, base_acc[hcbp_pkg::PEND_W-1:0]} | shifted;
        cnt_next = {3'b000, base_cnt[2:0]} + cmd.len;
      end
    end
  end

  // packer state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      flush_act <= 1'b0;
    end else begin
      acc       <= acc_next;
      cnt       <= cnt_next;
      flush_act <= flush_act_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_byte <= acc[7:0];
      last_of_run <= emit_last;
    end
  end

endmodule

>>> rtl/huffman_code_bit_packer_core.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Code table encoder with LSB-first byte packing.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation, symbol, code_length, code_bits.
// A load item writes a symbol's code length and bits into the table; an
// encode item appends that symbol's code to the pending bits; a flush item
// sends out a pending partial byte with zero high bits.
// Output channel (out_valid/out_ready): packed_byte and last_of_run, one byte
// per handshake; last_of_run marks the final byte caused by an input item.
// The first byte of an encode item goes through the table read, the queue
// push, the packer state and the output register on its way out.
// Throughput: one item per cycle enters while the queue has room; the packer
// sends one byte per cycle while out_ready allows, so an item that makes more
// than one byte holds the packer, which has a single byte path.
// A four-entry queue between the table front and the packer lets the input
// keep flowing while the packer waits on a stalled receiver; once the queue
// is full and the front holds a command, in_ready drops. The result byte
// holds while out_ready is low. Reset clears all code lengths (unloaded
// symbols emit nothing), the pending bits, the queue and the output register.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
  input  logic [hcbp_pkg::BITS_W-1:0] code_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  packed_byte,
  output logic                        last_of_run
);

  logic           f_valid;
  logic           f_ready;
  hcbp_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_ready;
  hcbp_pkg::cmd_t q_cmd;

  // table lookup front
  hcbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .symbol      (symbol),
    .code_length (code_length),
    .code_bits   (code_bits),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  // command queue
  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // bit packer and output register
  hcbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_byte (packed_byte),
    .last_of_run (last_of_run)
  );

endmodule
